// ----- rtl/core/periodic_register_report_scheduler_macros.svh -----
// Assertion macros for the periodic register report scheduler
`ifndef PERIODIC_REGISTER_REPORT_SCHEDULER_MACROS_SVH
`define PERIODIC_REGISTER_REPORT_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define PRRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("prrs check failed");

// Next-cycle implication, disabled while reset is asserted
`define PRRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prrs check failed");

`endif

// ----- rtl/core/prrs_pkg.sv -----
// Shared constants, types and codes of the periodic register report scheduler
package prrs_pkg;

  localparam int SLOTS     = 8;
  localparam int TIME_BITS = 48;
  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int REG_W     = 16;
  localparam int PER_W     = 16;
  localparam int NOW_W     = 48;
  localparam int ENTRY_W   = REG_W + PER_W;

  localparam logic [REG_W-1:0] EMPTY_REG = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_REPORT       = 2'd0,
    KIND_FULL         = 2'd1,
    KIND_NOT_IN_TABLE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_POLL,
    OP_REMOVE,
    OP_ADD
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_EMIT
  } state_e;

  // Updates to the per-slot flag bits
  typedef struct packed {
    logic              wr_a;
    logic              wr_b;
    logic              set_used;
    logic              clr_used;
    logic [SLOT_W-1:0] idx;
  } flag_upd_t;

  // Flag bits and derived status
  typedef struct packed {
    logic [SLOTS-1:0]  used;
    logic [SLOTS-1:0]  init_a;
    logic [SLOTS-1:0]  init_b;
    logic              full;
    logic [SLOT_W-1:0] free_idx;
  } flag_stat_t;

endpackage

// ----- rtl/core/prrs_if.sv -----
// Valid/ready channel interfaces for requests and results

interface prrs_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] reg_number;
  logic [15:0] period;
  logic [47:0] now;

  modport source (output valid, output func, output reg_number, output period,
                  output now, input ready);
  modport sink   (input valid, input func, input reg_number, input period,
                  input now, output ready);
endinterface

interface prrs_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [15:0] report_reg;

  modport source (output valid, output result_kind, output report_reg, input ready);
  modport sink   (input valid, input result_kind, input report_reg, output ready);
endinterface

// ----- rtl/core/prrs_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data
module prrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/core/prrs_flags.sv -----
// Per-slot used and written bits, table-full flag and first free slot
module prrs_flags (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  prrs_pkg::flag_upd_t   upd_i,
  output prrs_pkg::flag_stat_t  stat_o
);
  import prrs_pkg::*;

  logic [SLOTS-1:0]  used_q, used_d;
  logic [SLOTS-1:0]  init_a_q, init_a_d;
  logic [SLOTS-1:0]  init_b_q, init_b_d;
  logic [SLOT_W-1:0] free_idx;

  always_comb begin
    used_d   = used_q;
    init_a_d = init_a_q;
    init_b_d = init_b_q;
    if (upd_i.wr_a)     init_a_d[upd_i.idx] = 1'b1;
    if (upd_i.wr_b)     init_b_d[upd_i.idx] = 1'b1;
    if (upd_i.set_used) used_d[upd_i.idx]   = 1'b1;
    if (upd_i.clr_used) used_d[upd_i.idx]   = 1'b0;
  end

  // lowest unused slot wins
  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) free_idx = SLOT_W'(i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= '0;
      init_a_q <= '0;
      init_b_q <= '0;
    end else begin
      used_q   <= used_d;
      init_a_q <= init_a_d;
      init_b_q <= init_b_d;
    end
  end

  assign stat_o.used     = used_q;
  assign stat_o.init_a   = init_a_q;
  assign stat_o.init_b   = init_b_q;
  assign stat_o.full     = &used_q;
  assign stat_o.free_idx = free_idx;

endmodule

// ----- rtl/core/periodic_register_report_scheduler.sv -----
// A report, full or not-in-table result goes through ST_EMIT into the output register.
// Walks read, then check each slot in turn on the read port of each RAM; one item
// is in flight at a time.
// A new item is taken while the previous result still sits in the output register.
// Reset (async, active low) clears the slot flags and control; RAM contents are
// not cleared, slots never written read as empty through per-slot valid bits.
module periodic_register_report_scheduler (
  input  logic      clk_i,
  input  logic      rst_ni,
  prrs_req_if.sink  req_i,
  prrs_res_if.source res_o
);
  import prrs_pkg::*;

  `include "periodic_register_report_scheduler_macros.svh"

  state_e             state_q, state_d;
  op_e                op_q, op_d;
  logic [SLOT_W-1:0]  idx_q, idx_d;
  logic               out_valid_q, out_valid_d;

  logic [REG_W-1:0]     reg_q;
  logic [PER_W-1:0]     per_q;
  logic [TIME_BITS-1:0] now_q;
  kind_e                kind_q, kind_d;
  logic [REG_W-1:0]     rep_q, rep_d;
  kind_e                out_kind_q, out_kind_d;
  logic [REG_W-1:0]     out_reg_q, out_reg_d;

  flag_upd_t  upd;
  flag_stat_t stat;

  logic                 we_a, we_b;
  logic [SLOT_W-1:0]    waddr;
  logic [ENTRY_W-1:0]   wdata_a, rdata_a;
  logic [TIME_BITS-1:0] rdata_b, dl_sum;

  logic [REG_W-1:0]     cur_reg;
  logic [PER_W-1:0]     cur_per;
  logic [TIME_BITS-1:0] cur_dl;
  logic                 last, accept;

  prrs_flags u_flags (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (upd),
    .stat_o (stat)
  );

  // register number and period of each slot
  prrs_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS), .ADDR_W(SLOT_W)) u_ram_entry (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (wdata_a),
    .raddr_i (idx_q),
    .rdata_o (rdata_a)
  );

  // deadline of each slot
  prrs_ram #(.WIDTH(TIME_BITS), .DEPTH(SLOTS), .ADDR_W(SLOT_W)) u_ram_deadline (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (idx_q),
    .wdata_i (dl_sum),
    .raddr_i (idx_q),
    .rdata_o (rdata_b)
  );

  assign accept = req_i.valid && req_i.ready;
  assign last   = (idx_q == SLOT_W'(SLOTS - 1));

  // slots never written read as empty: EMPTY_REG, zero period and zero deadline
  assign cur_reg = stat.init_a[idx_q] ? rdata_a[ENTRY_W-1:PER_W] : EMPTY_REG;
  assign cur_per = stat.init_a[idx_q] ? rdata_a[PER_W-1:0] : '0;
  assign cur_dl  = stat.init_b[idx_q] ? rdata_b : '0;
  assign dl_sum  = now_q + TIME_BITS'(cur_per);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    idx_d       = idx_q;
    kind_d      = kind_q;
    rep_d       = rep_q;
    out_valid_d = out_valid_q;
    out_kind_d  = out_kind_q;
    out_reg_d   = out_reg_q;
    upd         = '0;
    upd.idx     = idx_q;
    we_a        = 1'b0;
    we_b        = 1'b0;
    waddr       = idx_q;
    wdata_a     = {reg_q, per_q};

    if (out_valid_q && res_o.ready) out_valid_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          idx_d = '0;
          if (req_i.func) begin
            op_d    = OP_POLL;
            state_d = ST_READ;
          end else if (req_i.period == '0) begin
            op_d    = OP_REMOVE;
            state_d = ST_READ;
          end else if (req_i.period == PER_W'(1)) begin
            kind_d  = KIND_REPORT;
            rep_d   = req_i.reg_number;
            state_d = ST_EMIT;
          end else if (stat.full) begin
            kind_d  = KIND_FULL;
            rep_d   = '0;
            state_d = ST_EMIT;
          end else begin
            op_d    = OP_ADD;
            state_d = ST_READ;
          end
        end
      end

      ST_READ: begin
        state_d = ST_CHECK;
      end

      ST_CHECK: begin
        state_d = ST_READ;
        idx_d   = idx_q + SLOT_W'(1);
        case (op_q)
          OP_POLL: begin
            if (stat.used[idx_q] && cur_per != '0 && now_q >= cur_dl) begin
              we_b       = 1'b1;
              upd.wr_b   = 1'b1;
              kind_d     = KIND_REPORT;
              rep_d      = cur_reg;
              state_d    = ST_EMIT;
            end else if (last) begin
              state_d = ST_IDLE;
            end
          end
          OP_REMOVE: begin
            if (cur_reg == reg_q) begin
              we_a         = 1'b1;
              wdata_a      = {EMPTY_REG, PER_W'(0)};
              upd.wr_a     = 1'b1;
              upd.clr_used = 1'b1;
              state_d      = ST_IDLE;
            end else if (last) begin
              kind_d  = KIND_NOT_IN_TABLE;
              rep_d   = '0;
              state_d = ST_EMIT;
            end
          end
          OP_ADD: begin
            if (cur_reg == reg_q) begin
              // renew: only the period changes, used flag stays as it is
              we_a     = 1'b1;
              upd.wr_a = 1'b1;
              state_d  = ST_IDLE;
            end else if (last) begin
              we_a         = 1'b1;
              waddr        = stat.free_idx;
              upd.idx      = stat.free_idx;
              upd.wr_a     = 1'b1;
              upd.set_used = 1'b1;
              state_d      = ST_IDLE;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end

      ST_EMIT: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d = 1'b1;
          out_kind_d  = kind_q;
          out_reg_d   = rep_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_POLL;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      reg_q <= req_i.reg_number;
      per_q <= req_i.period;
      now_q <= TIME_BITS'(req_i.now);
    end
    kind_q     <= kind_d;
    rep_q      <= rep_d;
    out_kind_q <= out_kind_d;
    out_reg_q  <= out_reg_d;
  end

  assign req_i.ready       = (state_q == ST_IDLE);
  assign res_o.valid       = out_valid_q;
  assign res_o.result_kind = out_kind_q;
  assign res_o.report_reg  = out_reg_q;

  `PRRS_ASSERT_NOW(a_add_not_full, clk_i, rst_ni, state_q == ST_CHECK && op_q == OP_ADD, !stat.full)
  `PRRS_ASSERT_NOW(a_used_written, clk_i, rst_ni, 1'b1, (stat.used & ~stat.init_a) == '0)
  `PRRS_ASSERT_NEXT(a_emit_loads, clk_i, rst_ni, state_q == ST_EMIT && (!out_valid_q || res_o.ready), out_valid_q && state_q == ST_IDLE)

endmodule

// ----- tb/tb_periodic_register_report_scheduler.sv -----
// Self-checking testbench for the periodic register report scheduler
`timescale 1ns / 1ps

module tb_periodic_register_report_scheduler;
  import prrs_pkg::*;

  localparam logic        FUNC_REQUEST = 1'b0;
  localparam logic        FUNC_POLL    = 1'b1;
  localparam logic [15:0] PER_REMOVE   = 16'd0;
  localparam logic [15:0] PER_ONCE     = 16'd1;
  localparam int          WALK_CYCLES  = 2 * SLOTS + 6;
  localparam int          MAX_SHOWN    = 10;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] reg_no;
  } report_t;

  logic clk_i;
  logic rst_ni;

  prrs_req_if req_if ();
  prrs_res_if res_if ();

  periodic_register_report_scheduler dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .res_o (res_if)
  );

  // Predicted copy of the slot table
  logic              tbl_used     [SLOTS];
  logic [15:0]       tbl_reg      [SLOTS];
  logic [15:0]       tbl_period   [SLOTS];
  logic [NOW_W-1:0]  tbl_deadline [SLOTS];

  report_t           pending_reports[$];
  logic [NOW_W-1:0]  clock_ms;

  int  err_count;
  int  n_requests;
  int  n_reports;
  int  n_full;
  int  n_absent;
  bit  tx_idle_en;
  bit  rx_idle_en;
  int  rx_hold_req;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic int find_slot(input logic [15:0] rn);
    for (int s = 0; s < SLOTS; s++) begin
      if (tbl_reg[s] == rn) return s;
    end
    return -1;
  endfunction

  // Applies one request to the table copy; returns 1 when a result is due
  function automatic bit schedule_step(input logic fn, input logic [15:0] rn,
                                       input logic [15:0] per, input logic [NOW_W-1:0] t_ms,
                                       output report_t rpt);
    int hit;
    bit full;
    rpt = '{kind: KIND_REPORT, reg_no: 16'h0000};
    hit = -1;
    full = 1'b1;
    if (fn == FUNC_POLL) begin
      for (int s = 0; s < SLOTS; s++) begin
        if (hit < 0 && tbl_used[s] && tbl_period[s] != 0 && t_ms >= tbl_deadline[s]) hit = s;
      end
      if (hit < 0) return 1'b0;
      tbl_deadline[hit] = t_ms + NOW_W'(tbl_period[hit]);
      rpt.reg_no = tbl_reg[hit];
      return 1'b1;
    end
    if (per == PER_REMOVE) begin
      hit = find_slot(rn);
      if (hit < 0) begin
        rpt.kind = KIND_NOT_IN_TABLE;
        return 1'b1;
      end
      tbl_reg[hit] = EMPTY_REG;
      tbl_period[hit] = '0;
      tbl_used[hit] = 1'b0;
      return 1'b0;
    end
    if (per == PER_ONCE) begin
      rpt.reg_no = rn;
      return 1'b1;
    end
    for (int s = 0; s < SLOTS; s++) begin
      if (!tbl_used[s]) full = 1'b0;
    end
    if (full) begin
      rpt.kind = KIND_FULL;
      return 1'b1;
    end
    // a request for the empty marker lands on the lowest empty slot
    hit = find_slot(rn);
    if (hit >= 0) begin
      tbl_period[hit] = per;
      return 1'b0;
    end
    for (int s = 0; s < SLOTS; s++) begin
      if (hit < 0 && !tbl_used[s]) hit = s;
    end
    tbl_reg[hit] = rn;
    tbl_period[hit] = per;
    tbl_used[hit] = 1'b1;
    return 1'b0;
  endfunction

  // Accepted requests feed the table copy; accepted results are checked in order
  always @(posedge clk_i) begin : track_and_check
    report_t rpt;
    report_t want;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        case (res_if.result_kind)
          KIND_REPORT: n_reports++;
          KIND_FULL:   n_full++;
          default:     n_absent++;
        endcase
        if (pending_reports.size() == 0) begin
          err_count++;
          if (err_count <= MAX_SHOWN)
            $display("[%0t] unexpected result: kind %0d reg %h", $realtime,
                     res_if.result_kind, res_if.report_reg);
        end else begin
          want = pending_reports.pop_front();
          if (res_if.result_kind !== want.kind || res_if.report_reg !== want.reg_no) begin
            err_count++;
            if (err_count <= MAX_SHOWN)
              $display("[%0t] result mismatch: expected kind %0d reg %h, got kind %0d reg %h",
                       $realtime, want.kind, want.reg_no, res_if.result_kind,
                       res_if.report_reg);
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        n_requests++;
        if (schedule_step(req_if.func, req_if.reg_number, req_if.period, req_if.now, rpt))
          pending_reports.push_back(rpt);
      end
    end
  end

  // Result side: random short stalls, plus a long hold-off on request
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    res_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else if (rx_hold_req > 0) begin
        res_if.ready <= 1'b0;
        stall_left = rx_hold_req - 1;
        rx_hold_req = 0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        res_if.ready <= 1'b0;
        stall_left = $urandom_range(1, 9) - 1;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Called on a rising edge; leaves valid high so back-to-back requests need no toggle
  task automatic send_item(input logic fn, input logic [15:0] rn, input logic [15:0] per,
                           input logic [NOW_W-1:0] t_ms);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.func       <= fn;
    req_if.reg_number <= rn;
    req_if.period     <= per;
    req_if.now        <= t_ms;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic send_request(input logic [15:0] rn, input logic [15:0] per);
    send_item(FUNC_REQUEST, rn, per, NOW_W'({$urandom, $urandom}));
  endtask

  task automatic send_poll(input logic [NOW_W-1:0] t_ms);
    send_item(FUNC_POLL, 16'($urandom), 16'($urandom), t_ms);
  endtask

  // Sender pause: wait for every result, then for a walk that yields none
  task automatic drain;
    req_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (WALK_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_directed;
    logic [15:0] fill_regs [8];
    logic [15:0] fill_pers [8];
    fill_regs = '{16'h0000, 16'h0001, 16'h8000, 16'h7FFF, 16'h00A5, 16'h5A00, 16'h1234,
                  16'hFFFE};
    fill_pers = '{16'd2, 16'hFFFF, 16'd3, 16'd2, 16'h8000, 16'd10, 16'd4, 16'h7FFF};
    send_request(16'h0000, PER_ONCE);
    send_request(16'hFFFF, PER_ONCE);
    send_request(16'h1234, PER_REMOVE);    // not in table
    send_poll('0);                         // empty table, nothing due
    for (int k = 0; k < 8; k++) send_request(fill_regs[k], fill_pers[k]);
    send_request(16'h4321, 16'd5);         // table full
    send_request(16'h0001, 16'd7);         // renew blocked while full
    send_request(16'hFFFF, 16'd2);
    send_poll('0);
    send_poll('0);
    send_poll({NOW_W{1'b1}});              // deadline wraps past the top
    send_request(16'h8000, PER_REMOVE);
    send_request(16'hFFFF, 16'd9);         // lands on the freed slot, stays unused
    send_poll({NOW_W{1'b1}});
    send_request(16'hFFFF, PER_REMOVE);
    send_request(16'hFFFF, PER_REMOVE);
    send_request(16'h0BAD, 16'd4);
    send_request(16'h0BAD, 16'd6);
    drain();
  endtask

  // Well-formed traffic on a small register pool with advancing time
  task automatic test_table_traffic(input int n_items);
    logic [15:0] pool [10];
    logic [15:0] rn;
    int          pick;
    foreach (pool[k]) pool[k] = 16'($urandom);
    for (int k = 0; k < n_items; k++) begin
      rn = ($urandom_range(0, 15) == 0) ? EMPTY_REG : pool[$urandom_range(0, 9)];
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        clock_ms += NOW_W'($urandom_range(0, 12));
        send_poll(clock_ms);
      end else if (pick < 70) begin
        send_request(rn, ($urandom_range(0, 9) == 0) ? 16'($urandom_range(2, 65535))
                                                     : 16'($urandom_range(2, 20)));
      end else if (pick < 85) begin
        send_request(rn, PER_REMOVE);
      end else if (pick < 95) begin
        send_request(rn, PER_ONCE);
      end else begin
        send_request(16'($urandom), PER_REMOVE);
      end
    end
  endtask

  // Output held off while requests keep coming: the block must stall its input
  task automatic test_output_stall;
    rx_hold_req = 400;
    for (int k = 0; k < 16; k++) send_request(16'($urandom), PER_ONCE);
    drain();
  endtask

  task automatic test_noise(input int n_items);
    logic [15:0] per;
    for (int k = 0; k < n_items; k++) begin
      per = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
      send_item(1'($urandom_range(0, 1)), 16'($urandom), per, NOW_W'({$urandom, $urandom}));
    end
    drain();
  endtask

  task automatic test_no_idle;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    clock_ms = {16'hFFFF, 32'hFFFF_FF00};  // starts just below the time wrap
    test_table_traffic(80);
    drain();
  endtask

  initial begin : stimulus
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.func       = FUNC_REQUEST;
    req_if.reg_number = '0;
    req_if.period     = '0;
    req_if.now        = '0;
    err_count   = 0;
    n_requests  = 0;
    n_reports   = 0;
    n_full      = 0;
    n_absent    = 0;
    rx_hold_req = 0;
    tx_idle_en  = 1'b1;
    rx_idle_en  = 1'b1;
    clock_ms    = '0;
    for (int s = 0; s < SLOTS; s++) begin
      tbl_used[s]     = 1'b0;
      tbl_reg[s]      = EMPTY_REG;
      tbl_period[s]   = '0;
      tbl_deadline[s] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    for (int blk = 0; blk < 5; blk++) begin
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      test_table_traffic(110);
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    drain();
    test_output_stall();
    test_noise(120);
    test_no_idle();

    if (pending_reports.size() != 0) err_count++;
    $display("covered %0d requests: %0d reports, %0d table full, %0d not in table",
             n_requests, n_reports, n_full, n_absent);
    $display("table corners, pooled traffic, long output stall, full-range noise, time wrap");
    if (err_count == 0) begin
      $display("tb_periodic_register_report_scheduler: done, clean");
    end else begin
      $display("%0d mismatches", err_count);
      $display("tb_periodic_register_report_scheduler: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("timeout with %0d results outstanding", pending_reports.size());
    $display("tb_periodic_register_report_scheduler: done, errors");
    $finish;
  end

endmodule
